// ===== rtl/dru_pkg.sv =====
`timescale 1ns / 1ps

package dru_pkg;

    localparam int NUM_CLASSES = 80;

    // Row layout: four box fields, then the class scores.
    localparam logic [6:0] BOX_FIELDS = 7'd4;
    localparam logic [6:0] SCORE_END  = 7'(4 + NUM_CLASSES);
    localparam logic [6:0] INDEX_MAX  = 7'd127;

    // Number of class enable bits held by the two enable registers.
    localparam logic [6:0] ENABLE_BITS = 7'd80;

    // Axis arithmetic widths.
    localparam int SUM_W  = 26;   // 2*c +/- s - pad*512, Q.9
    localparam int PROD_W = 51;   // SUM_W signed times 24-bit unsigned, Q.25
    localparam int MAG_W  = 26;   // rounded magnitude

    typedef enum logic [3:0] {
        CFG_SCORE_THRESHOLD   = 4'd0,
        CFG_PAD_LEFT          = 4'd1,
        CFG_PAD_TOP           = 4'd2,
        CFG_INVERSE_SCALE     = 4'd3,
        CFG_MAX_X             = 4'd4,
        CFG_MAX_Y             = 4'd5,
        CFG_CLASS_ENABLE_LOW  = 4'd6,
        CFG_CLASS_ENABLE_HIGH = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [23:0] element_value;
        logic               row_last;
    } dru_in_t;

    typedef struct packed {
        logic [15:0]        box_left;
        logic [15:0]        box_top;
        logic [15:0]        box_w;
        logic [15:0]        box_h;
        logic signed [23:0] box_score;
        logic [6:0]         box_class;
    } dru_out_t;

    typedef struct packed {
        logic [8:0]  score_threshold;
        logic [11:0] pad_left;
        logic [11:0] pad_top;
        logic [23:0] inverse_scale;
        logic [15:0] max_x;
        logic [15:0] max_y;
        logic [39:0] class_enable_low;
        logic [39:0] class_enable_high;
    } dru_cfg_t;

    // Completed row as seen by the box arithmetic.
    typedef struct packed {
        logic               valid;
        logic signed [23:0] ctr_x;
        logic signed [23:0] ctr_y;
        logic signed [23:0] width;
        logic signed [23:0] height;
        logic signed [23:0] score;
        logic [6:0]         class_id;
    } dru_row_t;

endpackage

// ===== rtl/dru_cfg_regs.sv =====
`timescale 1ns / 1ps

module dru_cfg_regs import dru_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [39:0] cfg_data,
    output dru_cfg_t    cfg
);

    dru_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.score_threshold   <= 9'd64;
            cfg_reg.pad_left          <= 12'd0;
            cfg_reg.pad_top           <= 12'd0;
            cfg_reg.inverse_scale     <= 24'd65536;
            cfg_reg.max_x             <= 16'd639;
            cfg_reg.max_y             <= 16'd479;
            cfg_reg.class_enable_low  <= '1;
            cfg_reg.class_enable_high <= '1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SCORE_THRESHOLD:   cfg_reg.score_threshold   <= cfg_data[8:0];
                CFG_PAD_LEFT:          cfg_reg.pad_left          <= cfg_data[11:0];
                CFG_PAD_TOP:           cfg_reg.pad_top           <= cfg_data[11:0];
                CFG_INVERSE_SCALE:     cfg_reg.inverse_scale     <= cfg_data[23:0];
                CFG_MAX_X:             cfg_reg.max_x             <= cfg_data[15:0];
                CFG_MAX_Y:             cfg_reg.max_y             <= cfg_data[15:0];
                CFG_CLASS_ENABLE_LOW:  cfg_reg.class_enable_low  <= cfg_data;
                CFG_CLASS_ENABLE_HIGH: cfg_reg.class_enable_high <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/dru_row_accum.sv =====
`timescale 1ns / 1ps

module dru_row_accum import dru_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  logic     in_fire,
    input  dru_in_t  in_data,
    output dru_row_t row
);

    localparam logic [1:0] FIELD_CX = 2'd0;
    localparam logic [1:0] FIELD_CY = 2'd1;
    localparam logic [1:0] FIELD_W  = 2'd2;

    logic [6:0]         index_reg, index_next;
    logic signed [23:0] ctr_x_reg, ctr_x_next;
    logic signed [23:0] ctr_y_reg, ctr_y_next;
    logic signed [23:0] width_reg, width_next;
    logic signed [23:0] height_reg, height_next;
    logic signed [23:0] lead_score_reg, lead_score_next;
    logic [6:0]         lead_class_reg, lead_class_next;
    logic               row_valid_reg, row_valid_next;
    logic signed [23:0] value;

    assign value = in_data.element_value;

    always_comb begin
        index_next      = index_reg;
        ctr_x_next      = ctr_x_reg;
        ctr_y_next      = ctr_y_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        lead_score_next = lead_score_reg;
        lead_class_next = lead_class_reg;
        row_valid_next  = 1'b0;
        if (in_fire) begin
            if (index_reg < BOX_FIELDS) begin
                case (index_reg[1:0])
                    FIELD_CX: ctr_x_next  = value;
                    FIELD_CY: ctr_y_next  = value;
                    FIELD_W:  width_next  = value;
                    default:  height_next = value;
                endcase
            end else if (index_reg < SCORE_END) begin
                // The first score always loads; later ones must be strictly larger.
                if (index_reg == BOX_FIELDS || value > lead_score_reg) begin
                    lead_score_next = value;
                    lead_class_next = index_reg - BOX_FIELDS;
                end
            end
            if (in_data.row_last) begin
                index_next = '0;
            end else if (index_reg < INDEX_MAX) begin
                index_next = index_reg + 7'd1;
            end
            row_valid_next = in_data.row_last && (index_reg >= BOX_FIELDS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg      <= '0;
            ctr_x_reg      <= '0;
            ctr_y_reg      <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            lead_score_reg <= '0;
            lead_class_reg <= '0;
            row_valid_reg  <= 1'b0;
        end else if (adv) begin
            index_reg      <= index_next;
            ctr_x_reg      <= ctr_x_next;
            ctr_y_reg      <= ctr_y_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            lead_score_reg <= lead_score_next;
            lead_class_reg <= lead_class_next;
            row_valid_reg  <= row_valid_next;
        end
    end

    // The box fields stay put while a completed row is read: the next row only
    // overwrites them from the edge that retires this one.
    assign row.valid    = row_valid_reg;
    assign row.ctr_x    = ctr_x_reg;
    assign row.ctr_y    = ctr_y_reg;
    assign row.width    = width_reg;
    assign row.height   = height_reg;
    assign row.score    = lead_score_reg;
    assign row.class_id = lead_class_reg;

`ifndef ASSERT_OFF
    a_no_row_without_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !in_data.row_last) |=> !row_valid_reg)
        else $error("row completed without a last element");

    a_row_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(row_valid_reg) |-> $past(in_fire && in_data.row_last))
        else $error("row completion not caused by a last element");

    a_class_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_valid_reg |-> (lead_class_reg < 7'(NUM_CLASSES)))
        else $error("best class index out of range");
`endif

endmodule

// ===== rtl/dru_axis.sv =====
`timescale 1ns / 1ps

module dru_axis import dru_pkg::*; (
    input  logic               aclk,
    input  logic               adv,
    input  logic signed [23:0] center,
    input  logic signed [23:0] extent,
    input  logic [11:0]        pad,
    input  logic [23:0]        inv_scale,
    input  logic [15:0]        limit,
    output logic [15:0]        near_side,
    output logic [15:0]        span
);

    localparam logic [PROD_W-1:0] RND_POS = PROD_W'(1 << 24);
    localparam logic [PROD_W-1:0] RND_NEG = PROD_W'((1 << 24) + 1);

    logic signed [SUM_W-1:0]  center2, extent_x, pad_x;
    logic signed [SUM_W-1:0]  lo_sum_reg, lo_sum_next, hi_sum_reg, hi_sum_next;
    logic signed [PROD_W-1:0] lo_prod_reg, lo_prod_next, hi_prod_reg, hi_prod_next;
    logic [PROD_W-1:0]        lo_rsum, hi_rsum;
    logic                     lo_neg_reg, hi_neg_reg;
    logic [MAG_W-1:0]         lo_mag_reg, hi_mag_reg;
    logic signed [MAG_W:0]    hi_val, diff;
    logic [15:0]              near_val;

    // Edges in Q.9: 2*c -/+ s - pad*512.
    assign center2     = {center[23], center, 1'b0};
    assign extent_x    = {{2{extent[23]}}, extent};
    assign pad_x       = $signed({5'b0, pad, 9'b0});
    assign lo_sum_next = center2 - extent_x - pad_x;
    assign hi_sum_next = center2 + extent_x - pad_x;

    assign lo_prod_next = lo_sum_reg * $signed({1'b0, inv_scale});
    assign hi_prod_next = hi_sum_reg * $signed({1'b0, inv_scale});

    // Magnitude plus one half in a single add: for a negative product the
    // two's complement and the half-LSB constant fold together.
    assign lo_rsum = lo_prod_reg[PROD_W-1] ? (~lo_prod_reg + RND_NEG)
                                           : (lo_prod_reg + RND_POS);
    assign hi_rsum = hi_prod_reg[PROD_W-1] ? (~hi_prod_reg + RND_NEG)
                                           : (hi_prod_reg + RND_POS);

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_sum_reg  <= lo_sum_next;
            hi_sum_reg  <= hi_sum_next;
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
            lo_neg_reg  <= lo_prod_reg[PROD_W-1];
            hi_neg_reg  <= hi_prod_reg[PROD_W-1];
            lo_mag_reg  <= lo_rsum[PROD_W-1:25];
            hi_mag_reg  <= hi_rsum[PROD_W-1:25];
        end
    end

    always_comb begin
        if (lo_neg_reg) begin
            near_val = '0;
        end else if (lo_mag_reg > MAG_W'(16'hFFFF)) begin
            near_val = 16'hFFFF;
        end else begin
            near_val = lo_mag_reg[15:0];
        end

        if (hi_neg_reg) begin
            hi_val = -$signed({1'b0, hi_mag_reg});
        end else if (hi_mag_reg > MAG_W'(limit)) begin
            hi_val = $signed({11'b0, limit});
        end else begin
            hi_val = $signed({1'b0, hi_mag_reg});
        end

        diff = hi_val - $signed({11'b0, near_val});
    end

    assign near_side = near_val;
    assign span      = diff[MAG_W] ? 16'd0 : diff[15:0];

endmodule

// ===== rtl/detection_row_decoder_unit.sv =====
`timescale 1ns / 1ps

// Decodes detection rows streamed one element per transaction: four box fields
// (center x, center y, width, height, signed Q15.8) followed by the class
// scores, with row_last on the final element. One element is accepted every
// cycle; a result waiting at the output holds the input only once another kept
// row has reached the stage just behind the output register. A kept row gives
// one result after its last element is accepted, by these steps in order: the row
// accumulator takes the element, then the edge sum, the multiply by
// inverse_scale and the rounding are each registered, and the clamp feeds the
// output register. Rows shorter than five elements, rows whose best class is
// disabled and rows whose best score is below score_threshold produce no
// result. Configuration writes are always taken at once and should be made
// only while no row is in flight.
module detection_row_decoder_unit import dru_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dru_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dru_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    dru_cfg_t           cfg;
    dru_row_t           row;
    logic               adv, out_free, in_fire;
    logic               class_enabled, score_ok, keep;
    logic [79:0]        enable_bits;
    logic [15:0]        x_near, x_span, y_near, y_span;
    logic               v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic signed [23:0] score1_reg, score2_reg, score3_reg;
    logic [6:0]         class1_reg, class2_reg, class3_reg;
    dru_out_t           m_data_reg;

    // The pipeline keeps moving behind a waiting result as long as the last
    // stage before the output register holds no kept row.
    assign out_free = !m_valid_reg || m_ready;
    assign adv      = out_free || !v3_reg;
    assign s_ready  = adv;
    assign in_fire  = s_valid && adv;

    dru_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dru_row_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_fire (in_fire),
        .in_data (s_data),
        .row     (row)
    );

    assign enable_bits   = {cfg.class_enable_high, cfg.class_enable_low};
    assign class_enabled = (row.class_id < ENABLE_BITS) ? enable_bits[row.class_id] : 1'b0;
    assign score_ok      = $signed({row.score[23], row.score})
                           >= $signed({16'b0, cfg.score_threshold});
    assign keep          = row.valid && class_enabled && score_ok;

    dru_axis u_axis_x (
        .aclk      (aclk),
        .adv       (adv),
        .center    (row.ctr_x),
        .extent    (row.width),
        .pad       (cfg.pad_left),
        .inv_scale (cfg.inverse_scale),
        .limit     (cfg.max_x),
        .near_side (x_near),
        .span      (x_span)
    );

    dru_axis u_axis_y (
        .aclk      (aclk),
        .adv       (adv),
        .center    (row.ctr_y),
        .extent    (row.height),
        .pad       (cfg.pad_top),
        .inv_scale (cfg.inverse_scale),
        .limit     (cfg.max_y),
        .near_side (y_near),
        .span      (y_span)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                v1_reg <= keep;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
            if (out_free) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            score1_reg <= row.score;
            class1_reg <= row.class_id;
            score2_reg <= score1_reg;
            class2_reg <= class1_reg;
            score3_reg <= score2_reg;
            class3_reg <= class2_reg;
        end
        if (out_free) begin
            m_data_reg.box_left  <= x_near;
            m_data_reg.box_top   <= y_near;
            m_data_reg.box_w     <= x_span;
            m_data_reg.box_h     <= y_span;
            m_data_reg.box_score <= score3_reg;
            m_data_reg.box_class <= class3_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_box_inside_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.box_w != 16'd0)
        |-> ({1'b0, m_data_reg.box_left} + {1'b0, m_data_reg.box_w}
             <= {1'b0, cfg.max_x}))
        else $error("box extends past the right clamp");

    a_box_inside_y: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.box_h != 16'd0)
        |-> ({1'b0, m_data_reg.box_top} + {1'b0, m_data_reg.box_h}
             <= {1'b0, cfg.max_y}))
        else $error("box extends past the bottom clamp");

    a_result_passes_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($signed({m_data_reg.box_score[23], m_data_reg.box_score})
                         >= $signed({16'b0, cfg.score_threshold}))
        && enable_bits[m_data_reg.box_class])
        else $error("result emitted for a row that should be dropped");
`endif

endmodule
